[src/sbd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbd_pkg
// Word types and elaboration-time sRGB decode and threshold tables for the
// 2x2 box downsampler.
// ----------------------------------------------------------------------------
package sbd_pkg;

  localparam int TAB_W  = 26;
  localparam int WIDE_W = 448;

  typedef logic [WIDE_W-1:0] wide_t;
  typedef logic [255:0][TAB_W-1:0] tab_t;

  typedef struct packed {
    logic [7:0] p00_red;
    logic [7:0] p00_green;
    logic [7:0] p00_blue;
    logic [7:0] p01_red;
    logic [7:0] p01_green;
    logic [7:0] p01_blue;
    logic [7:0] p10_red;
    logic [7:0] p10_green;
    logic [7:0] p10_blue;
    logic [7:0] p11_red;
    logic [7:0] p11_green;
    logic [7:0] p11_blue;
  } block_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } pixel_t;

  function automatic wide_t wide_pow(wide_t base, int unsigned e);
    wide_t x;
    x = WIDE_W'(1);
    for (int unsigned i = 0; i < e; i++) begin
      x = x * base;
    end
    return x;
  endfunction

  // linear value of code c, times 2^lin_bits-1, rounded half up
  function automatic logic [31:0] dec_entry(int unsigned c, int unsigned lin_bits);
    logic [63:0] one;
    logic [63:0] n;
    wide_t       den12;
    wide_t       rhs;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] mid;
    one = (64'd1 << lin_bits) - 64'd1;
    if (c <= 10) begin
      n = 64'd200 * 64'(c) * one + 64'd329460;
      return 32'(n / 64'd658920);
    end
    den12 = wide_pow(WIDE_W'(269025), 12);
    rhs   = wide_pow(WIDE_W'(1000 * c + 14025), 12) * wide_pow(WIDE_W'(2 * one), 5);
    lo    = 32'd0;
    hi    = 32'(one);
    while (lo < hi) begin
      mid = lo + ((hi - lo + 32'd1) >> 1);
      if (den12 * wide_pow(WIDE_W'(2 * mid - 32'd1), 5) <= rhs) begin
        lo = mid;
      end else begin
        hi = mid - 32'd1;
      end
    end
    return lo;
  endfunction

  // smallest four-pixel sum whose average reaches code k minus one half
  function automatic logic [31:0] thr_entry(int unsigned k, int unsigned lin_bits);
    logic [63:0] four;
    logic [63:0] n;
    wide_t       den12;
    wide_t       rhs;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] mid;
    four = ((64'd1 << lin_bits) - 64'd1) << 2;
    if (k <= 10) begin
      n = 64'(2 * k - 1) * 64'd100 * four + 64'd658919;
      return 32'(n / 64'd658920);
    end
    den12 = wide_pow(WIDE_W'(538050), 12);
    rhs   = wide_pow(WIDE_W'(1000 * (2 * k - 1) + 28050), 12) * wide_pow(WIDE_W'(four), 5);
    lo    = 32'd0;
    hi    = 32'(four);
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (den12 * wide_pow(WIDE_W'(mid), 5) >= rhs) begin
        hi = mid;
      end else begin
        lo = mid + 32'd1;
      end
    end
    return lo;
  endfunction

  function automatic tab_t dec_table(int unsigned lin_bits);
    tab_t t;
    for (int unsigned i = 0; i < 256; i++) begin
      t[i] = TAB_W'(dec_entry(i, lin_bits));
    end
    return t;
  endfunction

  function automatic tab_t thr_table(int unsigned lin_bits);
    tab_t t;
    t[0] = '0;
    for (int unsigned i = 1; i < 256; i++) begin
      t[i] = TAB_W'(thr_entry(i, lin_bits));
    end
    return t;
  endfunction

endpackage

[src/sbd_decode_sum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbd_decode_sum
// Decodes four sRGB codes of one channel to linear light and registers
// their sum.
// ----------------------------------------------------------------------------
module sbd_decode_sum
  import sbd_pkg::*;
#(
  parameter int LINEAR_BITS = 16
) (
  input  logic                   clk,
  input  logic [7:0]             c0,
  input  logic [7:0]             c1,
  input  logic [7:0]             c2,
  input  logic [7:0]             c3,
  output logic [LINEAR_BITS+1:0] sum
);

  localparam tab_t DEC_TAB = dec_table(LINEAR_BITS);

  logic [LINEAR_BITS-1:0] l0, l1, l2, l3;
  logic [LINEAR_BITS+1:0] sum_next;

  always_comb begin
    l0 = DEC_TAB[c0][LINEAR_BITS-1:0];
    l1 = DEC_TAB[c1][LINEAR_BITS-1:0];
    l2 = DEC_TAB[c2][LINEAR_BITS-1:0];
    l3 = DEC_TAB[c3][LINEAR_BITS-1:0];
    sum_next = {2'b00, l0} + {2'b00, l1} + {2'b00, l2} + {2'b00, l3};
  end

  always_ff @(posedge clk) begin
    sum <= sum_next;
  end

endmodule

[src/sbd_encode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbd_encode
// Encodes a four-pixel linear sum back to an sRGB code by binary search
// over the rounding thresholds.
// ----------------------------------------------------------------------------
module sbd_encode
  import sbd_pkg::*;
#(
  parameter int LINEAR_BITS = 16
) (
  input  logic [LINEAR_BITS+1:0] sum,
  output logic [7:0]             code
);

  localparam tab_t THR_TAB = thr_table(LINEAR_BITS);

  always_comb begin
    logic [7:0] k;
    logic [7:0] cand;
    k = 8'd0;
    for (int b = 7; b >= 0; b--) begin
      cand = k | (8'd1 << b);
      if (THR_TAB[cand][LINEAR_BITS+1:0] <= sum) begin
        k = cand;
      end
    end
    code = k;
  end

endmodule

[src/srgb_2x2_box_downsample.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srgb_2x2_box_downsample
// Gamma-correct 2x2 box filter: four sRGB pixels in, one averaged pixel out.
// ----------------------------------------------------------------------------
// One block word is taken on every cycle in which start is high and busy is
// low; busy is high only during reset. Each word gives one pixel word through
// the input register, the decode-and-sum register and the result register,
// shown for one cycle with done high. The receiver cannot stall, so the
// block runs at one word per clock with no gaps. Alpha is always 255.
// ----------------------------------------------------------------------------
module srgb_2x2_box_downsample
  import sbd_pkg::*;
#(
  parameter int LINEAR_BITS = 16
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  output logic   busy,
  input  block_t block,
  output logic   done,
  output pixel_t pixel
);

  logic                   accept;
  logic                   v1;
  logic                   v2;
  block_t                 blk_q;
  logic [LINEAR_BITS+1:0] sum_r, sum_g, sum_b;
  logic [7:0]             enc_r, enc_g, enc_b;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    blk_q <= block;
    pixel <= '{out_red: enc_r, out_green: enc_g, out_blue: enc_b, out_alpha: 8'hFF};
  end

  sbd_decode_sum #(.LINEAR_BITS(LINEAR_BITS)) u_sum_r (
    .clk (clk),
    .c0  (blk_q.p00_red),
    .c1  (blk_q.p01_red),
    .c2  (blk_q.p10_red),
    .c3  (blk_q.p11_red),
    .sum (sum_r)
  );

  sbd_decode_sum #(.LINEAR_BITS(LINEAR_BITS)) u_sum_g (
    .clk (clk),
    .c0  (blk_q.p00_green),
    .c1  (blk_q.p01_green),
    .c2  (blk_q.p10_green),
    .c3  (blk_q.p11_green),
    .sum (sum_g)
  );

  sbd_decode_sum #(.LINEAR_BITS(LINEAR_BITS)) u_sum_b (
    .clk (clk),
    .c0  (blk_q.p00_blue),
    .c1  (blk_q.p01_blue),
    .c2  (blk_q.p10_blue),
    .c3  (blk_q.p11_blue),
    .sum (sum_b)
  );

  sbd_encode #(.LINEAR_BITS(LINEAR_BITS)) u_enc_r (.sum(sum_r), .code(enc_r));
  sbd_encode #(.LINEAR_BITS(LINEAR_BITS)) u_enc_g (.sum(sum_g), .code(enc_g));
  sbd_encode #(.LINEAR_BITS(LINEAR_BITS)) u_enc_b (.sum(sum_b), .code(enc_b));

  // every accepted word comes out with done, through the pipeline registers
  a_word_out: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 done)
    else $error("accepted word gave no result");

  // no result without an earlier word taken
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 3))
    else $error("result without accepted word");

  a_alpha: assert property (@(posedge clk) disable iff (rst)
    done |-> pixel.out_alpha == 8'hFF)
    else $error("alpha not opaque");

  // a flat red channel survives the round trip
  a_flat_red: assert property (@(posedge clk) disable iff (rst)
    (done && $past(block.p00_red == block.p01_red && block.p00_red == block.p10_red
                   && block.p00_red == block.p11_red, 3))
      |-> pixel.out_red == $past(block.p00_red, 3))
    else $error("flat red block not preserved");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the sRGB 2x2 box downsampler. A driver feeds
// block words from a queue, a monitor predicts each pixel word from exact
// integer decode and threshold tables and checks the strobed results in
// order. Runs directed blocks, then random blocks under several idle phases.
// ----------------------------------------------------------------------------
module tb_top;
  import sbd_pkg::*;

  localparam int LIN_BITS  = 16;
  localparam int WDOG_MAX  = 2000;
  localparam int RAND_ITEMS = 500;

  typedef logic [383:0] big_t;

  logic   clk;
  logic   rst;
  logic   start;
  logic   busy;
  block_t block;
  logic   done;
  pixel_t pixel;

  block_t pending_blocks[$];
  pixel_t awaited_pixels[$];

  int unsigned lin_of_code[256];
  int unsigned min_sum_of_code[256];

  logic took;
  int   sender_idle_pct;
  int   accepted_count;
  int   queued_count;
  int   quiet_cycles;
  int   fail_count;

  srgb_2x2_box_downsample #(.LINEAR_BITS(LIN_BITS)) DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .block (block),
    .done  (done),
    .pixel (pixel)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic big_t big_pow(big_t b, int unsigned e);
    big_t r;
    r = big_t'(1);
    for (int unsigned i = 0; i < e; i++) r = r * b;
    return r;
  endfunction

  // exact decode: largest m with (2m-1)/(2S) not above the linear value;
  // threshold: smallest t with t/(4S) not below the linear value of k-0.5
  function automatic void build_tables();
    longint unsigned s_one;
    big_t            dec_den12;
    big_t            thr_den12;
    big_t            rhs;
    real             lin;
    longint          m;
    longint          t;
    s_one     = (64'd1 << LIN_BITS) - 1;
    dec_den12 = big_pow(big_t'(269025), 12);
    thr_den12 = big_pow(big_t'(538050), 12);
    for (int c = 0; c < 256; c++) begin
      if (c <= 10) begin
        lin_of_code[c] = int'((64'd200 * c * s_one + 64'd329460) / 64'd658920);
      end else begin
        rhs = big_pow(big_t'(1000 * c + 14025), 12) * big_pow(big_t'(2 * s_one), 5);
        lin = ((c / 255.0 + 0.055) / 1.055) ** 2.4;
        m = $rtoi(s_one * lin + 0.5);
        if (m < 0) m = 0;
        if (m > s_one) m = s_one;
        while (m > 0 && dec_den12 * big_pow(big_t'(2 * m - 1), 5) > rhs) m--;
        while (m < s_one && dec_den12 * big_pow(big_t'(2 * m + 1), 5) <= rhs) m++;
        lin_of_code[c] = int'(m);
      end
    end
    min_sum_of_code[0] = 0;
    for (int k = 1; k < 256; k++) begin
      if (k <= 10) begin
        min_sum_of_code[k] =
          int'(((2 * k - 1) * 64'd100 * 4 * s_one + 64'd658919) / 64'd658920);
      end else begin
        rhs = big_pow(big_t'(1000 * (2 * k - 1) + 28050), 12) *
              big_pow(big_t'(4 * s_one), 5);
        lin = (((k - 0.5) / 255.0 + 0.055) / 1.055) ** 2.4;
        t = $rtoi(4 * s_one * lin) + 1;
        if (t < 0) t = 0;
        if (t > 4 * s_one) t = 4 * s_one;
        while (t < 4 * s_one && thr_den12 * big_pow(big_t'(t), 5) < rhs) t++;
        while (t > 0 && thr_den12 * big_pow(big_t'(t - 1), 5) >= rhs) t--;
        min_sum_of_code[k] = int'(t);
      end
    end
  endfunction

  function automatic logic [7:0] to_srgb_code(int unsigned lin_sum);
    logic [7:0] k;
    k = 8'd0;
    for (int i = 1; i < 256; i++) begin
      if (min_sum_of_code[i] <= lin_sum) k = i[7:0];
    end
    return k;
  endfunction

  function automatic pixel_t predict_pixel(block_t b);
    logic [95:0]  raw;
    logic [7:0]   code [3];
    int unsigned  lin_sum;
    pixel_t       p;
    raw = b;
    for (int ch = 0; ch < 3; ch++) begin
      lin_sum = 0;
      for (int px = 0; px < 4; px++) begin
        lin_sum += lin_of_code[raw[95 - 8 * (3 * px + ch) -: 8]];
      end
      code[ch] = to_srgb_code(lin_sum);
    end
    p.out_red   = code[0];
    p.out_green = code[1];
    p.out_blue  = code[2];
    p.out_alpha = 8'd255;
    return p;
  endfunction

  function automatic block_t rgb_block(logic [7:0] r[4], logic [7:0] g[4],
                                       logic [7:0] bl[4]);
    logic [95:0] raw;
    for (int px = 0; px < 4; px++) begin
      raw[95 - 8 * (3 * px)     -: 8] = r[px];
      raw[95 - 8 * (3 * px + 1) -: 8] = g[px];
      raw[95 - 8 * (3 * px + 2) -: 8] = bl[px];
    end
    return block_t'(raw);
  endfunction

  function automatic logic [7:0] near_byte(int base);
    int v;
    v = base + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic block_t random_block();
    logic [7:0] r[4];
    logic [7:0] g[4];
    logic [7:0] bl[4];
    logic [7:0] picks[6];
    int         mode;
    int         base[3];
    picks = '{8'd0, 8'd1, 8'd10, 8'd11, 8'd254, 8'd255};
    mode = int'($urandom_range(0, 9));
    for (int ch = 0; ch < 3; ch++) base[ch] = int'($urandom_range(0, 255));
    for (int px = 0; px < 4; px++) begin
      if (mode <= 5) begin
        r[px] = 8'($urandom); g[px] = 8'($urandom); bl[px] = 8'($urandom);
      end else if (mode <= 7) begin
        r[px] = near_byte(base[0]); g[px] = near_byte(base[1]);
        bl[px] = near_byte(base[2]);
      end else if (mode == 8) begin
        r[px] = base[0][7:0]; g[px] = base[1][7:0]; bl[px] = base[2][7:0];
      end else begin
        r[px] = picks[$urandom_range(0, 5)];
        g[px] = picks[$urandom_range(0, 5)];
        bl[px] = picks[$urandom_range(0, 5)];
      end
    end
    return rgb_block(r, g, bl);
  endfunction

  task automatic push_uniform(logic [7:0] r, logic [7:0] g, logic [7:0] bl);
    logic [7:0] ra[4];
    logic [7:0] ga[4];
    logic [7:0] ba[4];
    ra = '{r, r, r, r};
    ga = '{g, g, g, g};
    ba = '{bl, bl, bl, bl};
    pending_blocks = {pending_blocks, rgb_block(ra, ga, ba)};
  endtask

  task automatic push_gray4(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                            logic [7:0] d);
    logic [7:0] v[4];
    v = '{a, b, c, d};
    pending_blocks = {pending_blocks, rgb_block(v, v, v)};
  endtask

  task automatic push_directed();
    logic [7:0] r[4];
    logic [7:0] g[4];
    logic [7:0] bl[4];
    push_uniform(8'd0, 8'd0, 8'd0);
    push_uniform(8'd255, 8'd255, 8'd255);
    push_uniform(8'd128, 8'd64, 8'd200);
    push_uniform(8'd10, 8'd11, 8'd12);
    push_uniform(8'd1, 8'd254, 8'd9);
    push_uniform(8'd255, 8'd0, 8'd255);
    push_gray4(8'd0, 8'd255, 8'd255, 8'd0);
    push_gray4(8'd255, 8'd0, 8'd0, 8'd0);
    push_gray4(8'd0, 8'd255, 8'd255, 8'd255);
    push_gray4(8'd0, 8'd0, 8'd0, 8'd1);
    push_gray4(8'd10, 8'd11, 8'd10, 8'd11);
    push_gray4(8'd254, 8'd255, 8'd255, 8'd255);
    r  = '{8'd255, 8'd0, 8'd0, 8'd255};
    g  = '{8'd0, 8'd255, 8'd0, 8'd0};
    bl = '{8'd0, 8'd0, 8'd255, 8'd170};
    pending_blocks = {pending_blocks, rgb_block(r, g, bl)};
    pending_blocks = {pending_blocks, block_t'(96'h55aa55_aa55aa_0ff00f_f00ff0)};
  endtask

  // driver: on the falling edge once the previous word was taken, a new word or an idle cycle
  always @(negedge clk) begin
    if (!start || took) begin
      if (pending_blocks.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        block <= pending_blocks.pop_front();
        start <= 1'b1;
      end else begin
        block <= block_t'({$urandom, $urandom, $urandom});
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on accept, check on done, watchdog on silence
  always @(posedge clk) begin
    pixel_t want;
    took = start && !busy;
    if (took) begin
      awaited_pixels = {awaited_pixels, predict_pixel(block)};
      accepted_count++;
    end
    if (!rst && done) begin
      if (awaited_pixels.size() == 0) begin
        $error("unexpected pixel word %h", pixel);
        fail_count++;
      end else begin
        want = awaited_pixels.pop_front();
        if (pixel.out_red !== want.out_red) begin
          $error("out_red: expected %0d, got %0d", want.out_red, pixel.out_red);
          fail_count++;
        end
        if (pixel.out_green !== want.out_green) begin
          $error("out_green: expected %0d, got %0d", want.out_green, pixel.out_green);
          fail_count++;
        end
        if (pixel.out_blue !== want.out_blue) begin
          $error("out_blue: expected %0d, got %0d", want.out_blue, pixel.out_blue);
          fail_count++;
        end
        if (pixel.out_alpha !== want.out_alpha) begin
          $error("out_alpha: expected %0d, got %0d", want.out_alpha, pixel.out_alpha);
          fail_count++;
        end
      end
    end
    if (took || done || rst) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WDOG_MAX) begin
      $display("watchdog expired, %0d pixel words outstanding", awaited_pixels.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int idle_by_phase[4];
    idle_by_phase   = '{0, 81, 0, 17};
    rst             = 1'b1;
    start           = 1'b0;
    block           = '0;
    took            = 1'b0;
    sender_idle_pct = 0;
    accepted_count  = 0;
    queued_count    = 0;
    quiet_cycles    = 0;
    fail_count      = 0;
    build_tables();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      @(posedge clk);
      sender_idle_pct = idle_by_phase[ph];
      if (ph == 0) push_directed();
      repeat (RAND_ITEMS) pending_blocks = {pending_blocks, random_block()};
      queued_count += pending_blocks.size();
      while (accepted_count < queued_count || awaited_pixels.size() != 0) begin
        @(negedge clk);
      end
    end
    repeat (8) @(negedge clk);
    if (fail_count == 0 && awaited_pixels.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
